FILE: rtl/qwt_pkg.sv
// Shared types and constants for the quoted word tokenizer.
package qwt_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned CountW = 12;
  localparam int unsigned KindW = 2;
  localparam int unsigned OutDataW = 24;

  localparam logic [CountW-1:0] CapacityReset = 12'd255;

  localparam logic [CharW-1:0] ChSQuote = 8'h27;
  localparam logic [CharW-1:0] ChDQuote = 8'h22;
  localparam logic [CharW-1:0] ChNl     = 8'h0A;
  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChTab    = 8'h09;

  typedef enum logic [KindW-1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_NONE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_LEAD  = 2'd1,
    PH_WORD  = 2'd2
  } phase_e;

  typedef struct packed {
    phase_e            phase;
    logic              in_squote;
    logic              in_dquote;
    logic [CountW-1:0] count;
    logic              nl_seen;
  } tok_state_t;

  typedef struct packed {
    logic              valid;
    kind_e             kind;
    logic [CharW-1:0]  ch;
    logic [CountW-1:0] len;
    logic              line_ended;
  } tok_result_t;

  localparam tok_state_t StateRearm = '{
    phase: PH_FIRST, in_squote: 1'b0, in_dquote: 1'b0, count: '0, nl_seen: 1'b0
  };

endpackage

FILE: rtl/qwt_step.sv
// Per-character tokenizer decision: next state and optional result.
module qwt_step
  import qwt_pkg::*;
(
  input  logic [CharW-1:0]  char_i,
  input  logic              eoi_i,
  input  tok_state_t        state_i,
  input  logic [CountW-1:0] capacity_i,
  output tok_state_t        state_o,
  output tok_result_t       result_o
);

  logic is_blank;
  logic is_nl;
  logic quoted;

  assign is_blank = (char_i == ChSpace) || (char_i == ChTab);
  assign is_nl    = (char_i == ChNl);
  assign quoted   = state_i.in_squote || state_i.in_dquote;

  always_comb begin
    state_o  = state_i;
    result_o = '{valid: 1'b0, kind: KIND_CHAR, ch: '0, len: '0, line_ended: 1'b0};
    if (eoi_i) begin
      state_o         = StateRearm;
      result_o.valid  = 1'b1;
      if (state_i.phase == PH_FIRST) begin
        result_o.kind = KIND_NONE;
      end else begin
        result_o.kind       = KIND_END;
        result_o.len        = state_i.count;
        result_o.line_ended = state_i.nl_seen;
      end
    end else if (state_i.phase != PH_WORD && is_blank) begin
      state_o.phase = PH_LEAD;
    end else begin
      state_o.phase = PH_WORD;
      if (char_i == ChSQuote && !state_i.in_dquote) begin
        state_o.in_squote = !state_i.in_squote;
      end else if (char_i == ChDQuote && !state_i.in_squote) begin
        state_o.in_dquote = !state_i.in_dquote;
      end else if (((is_nl || is_blank) && !quoted) || (state_i.count >= capacity_i)) begin
        // word ends; a dropped newline still marks the line
        state_o             = StateRearm;
        result_o.valid      = 1'b1;
        result_o.kind       = KIND_END;
        result_o.len        = state_i.count;
        result_o.line_ended = state_i.nl_seen || is_nl;
      end else begin
        state_o.count   = state_i.count + CountW'(1);
        state_o.nl_seen = state_i.nl_seen || is_nl;
        result_o.valid  = 1'b1;
        result_o.kind   = KIND_CHAR;
        result_o.ch     = char_i;
      end
    end
  end

endmodule

FILE: rtl/quoted_word_tokenizer_core.sv
// Shell-style quoted word tokenizer: one character transfer in, at most one result out.
// Takes one character (or an end-of-input mark in s_axis_tuser) per cycle unless the
// output stalls; results pass the input register, then the result register. The
// tokenizer state is updated by combinational decision logic, which allows a new
// character every cycle; output backpressure reaches s_axis_tready combinationally.
// Unquoted spaces are not emitted; each word gives its characters one by one and then
// a word-ended result with its length. word_capacity is written through
// cfg_we_i/cfg_wdata_i by the user only while no transfer is in flight (not enforced).
module quoted_word_tokenizer_core
  import qwt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CountW-1:0]   cfg_wdata_i,    // word_capacity
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [CharW-1:0]    s_axis_tdata,   // [7:0] char_in
  input  logic                s_axis_tuser,   // end_of_input
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [7:0] char_out, [19:8] word_length,
                                              // [20] line_ended, [23:21] zero
  output logic [KindW-1:0]    m_axis_tuser    // kind
);

  logic [CountW-1:0] capacity_q;
  logic              in_valid_q;
  logic [CharW-1:0]  in_char_q;
  logic              in_eoi_q;
  tok_state_t        state_q, state_d;
  tok_result_t       result;
  logic              out_valid_q;
  tok_result_t       out_q;
  logic              out_ready;
  logic              step_fire;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign step_fire     = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;

  qwt_step u_step (
    .char_i     (in_char_q),
    .eoi_i      (in_eoi_q),
    .state_i    (state_q),
    .capacity_i (capacity_q),
    .state_o    (state_d),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= CapacityReset;
      in_valid_q  <= 1'b0;
      state_q     <= StateRearm;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (step_fire) begin
        state_q <= state_d;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q && result.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
      in_eoi_q  <= s_axis_tuser;
    end
    if (step_fire) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {{(OutDataW - CharW - CountW - 1){1'b0}},
                          out_q.line_ended, out_q.len, out_q.ch};

  a_first_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_FIRST |-> state_q == StateRearm)
    else $error("idle phase with leftover word state");

  a_lead_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_LEAD |->
      (state_q.count == '0 && !state_q.in_squote && !state_q.in_dquote && !state_q.nl_seen))
    else $error("leading-blank phase with word state");

  a_rearm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_fire && result.valid && result.kind != KIND_CHAR) |=> state_q == StateRearm)
    else $error("tokenizer not rearmed after word end");

  a_char_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == KIND_CHAR) |-> (out_q.len == '0 && !out_q.line_ended))
    else $error("character result carries word-end fields");

endmodule
